### rtl/core/ground_spoiler_deploy_logic_assert.svh
// Assertion macros used by the checker file of the spoiler controller.
// No dependencies; include by bare file name.
`ifndef GROUND_SPOILER_DEPLOY_LOGIC_ASSERT_SVH
`define GROUND_SPOILER_DEPLOY_LOGIC_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define GSDL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define GSDL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/gsdl_pkg.sv
// Package for the ground spoiler controller: types, command codes, register map.
// No dependencies; used by every module of the block.
package gsdl_pkg;

	localparam int unsigned TDATA_IN_W  = 112;
	localparam int unsigned TDATA_OUT_W = 40;
	localparam int unsigned TUSER_IN_W  = 4;
	localparam int unsigned PADDR_W     = 5;

	localparam logic [14:0] FULL_POS = 15'd16384;
	localparam logic [14:0] HALF_POS = 15'd8192;

	localparam logic [3:0] CMD_TICK       = 4'd0;
	localparam logic [3:0] CMD_ON         = 4'd1;
	localparam logic [3:0] CMD_OFF        = 4'd2;
	localparam logic [3:0] CMD_TOGGLE     = 4'd3;
	localparam logic [3:0] CMD_SET        = 4'd4;
	localparam logic [3:0] CMD_AXIS       = 4'd5;
	localparam logic [3:0] CMD_ARM_ON     = 4'd6;
	localparam logic [3:0] CMD_ARM_OFF    = 4'd7;
	localparam logic [3:0] CMD_ARM_TOGGLE = 4'd8;
	localparam logic [3:0] CMD_ARM_SET    = 4'd9;
	localparam logic [3:0] CMD_INIT       = 4'd10;

	localparam logic [2:0] REG_AP_LIMIT  = 3'd0;
	localparam logic [2:0] REG_PARTIAL   = 3'd1;
	localparam logic [2:0] REG_SPEED_THR = 3'd2;
	localparam logic [2:0] REG_MIN_AIR   = 3'd3;
	localparam logic [2:0] REG_IDLE      = 3'd4;
	localparam logic [2:0] REG_CLIMB     = 3'd5;
	localparam logic [2:0] REG_MCT       = 3'd6;
	localparam logic [2:0] REG_TOUCH_GO  = 3'd7;

	typedef struct packed {
		logic        [14:0] ap_limit;
		logic        [14:0] partial_pos;
		logic        [9:0]  speed_thr;
		logic        [15:0] min_air_ms;
		logic signed [9:0]  idle_angle;
		logic signed [9:0]  climb_angle;
		logic signed [9:0]  mct_angle;
		logic signed [9:0]  touch_go_angle;
	} cfg_t;

	typedef struct packed {
		logic        [3:0]  cmd;
		logic signed [15:0] value;
		logic        [31:0] sim_time_ms;
		logic               autopilot_engaged;
		logic        [9:0]  airspeed_kt;
		logic signed [9:0]  lever_angle_left;
		logic signed [9:0]  lever_angle_right;
		logic        [14:0] gear_left_anim;
		logic        [14:0] gear_right_anim;
	} item_t;

	typedef struct packed {
		logic               armed;
		logic        [14:0] handle;
		logic        [14:0] surface;
		logic               initialized;
		logic        [31:0] stamp;
		logic               stamp_valid;
		logic               landing;
		logic               takeoff;
		logic               ap_latched;
		logic        [31:0] last_time;
		logic        [9:0]  last_speed;
		logic signed [9:0]  angle_left;
		logic signed [9:0]  angle_right;
		logic        [1:0]  gear;
	} state_t;

	typedef struct packed {
		logic [14:0] spoiler_position;
		logic [14:0] handle_out;
		logic        armed_out;
		logic        landing_active;
		logic        takeoff_active;
	} result_t;

endpackage

### rtl/core/ground_spoiler_deploy_logic.sv
// Ground spoiler controller: input register, state, evaluation, result register.
// Depends on gsdl_pkg, gsdl_cfg and gsdl_eval.
//
// Usage:
//  Slave stream (s_tvalid/s_tready/s_tdata/s_tuser) carries one event or sensor
//  tick per transaction; s_tuser holds the command code. Master stream
//  (m_tvalid/m_tready/m_tdata) returns exactly one result per input transaction,
//  in order.
//  APB port writes the eight tuning registers at byte addresses 0..28;
//  write only while the block holds no pending work.
//  Pipeline: the input register holds the item, the result register its result.
//  Throughput: one transaction per cycle while m_tready stays high; the state
//  update for an item loops through the evaluation logic into the state
//  register, so the next item sees it directly.
//  Stall: when m_tready is low the result register holds; one more item waits
//  in the input register, then s_tready drops until the result is taken.
//  Reset: all controller state clears to zero (handle retracted, disarmed, no
//  landing or take-off condition), registers return to their defaults, both
//  streams empty.
module ground_spoiler_deploy_logic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// value, sim_time_ms, autopilot_engaged, airspeed_kt, lever_angle_left,
	// lever_angle_right, gear_left_anim, gear_right_anim, zero pad
	input  logic [gsdl_pkg::TDATA_IN_W-1:0]   s_tdata,
	// cmd
	input  logic [gsdl_pkg::TUSER_IN_W-1:0]   s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// spoiler_position, handle_out, armed_out, landing_active, takeoff_active,
	// zero pad
	output logic [gsdl_pkg::TDATA_OUT_W-1:0]  m_tdata,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gsdl_pkg::PADDR_W-1:0]      paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	gsdl_pkg::cfg_t    cfg;
	gsdl_pkg::item_t   item_in;
	gsdl_pkg::item_t   item_s1;
	logic              valid_s1;
	gsdl_pkg::state_t  st_q;
	gsdl_pkg::state_t  st_nx;
	gsdl_pkg::result_t res;
	gsdl_pkg::result_t res_s2;
	logic              valid_s2;
	logic              fire;
	logic              s_accept;

	gsdl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign item_in.cmd               = s_tuser;
	assign item_in.value             = s_tdata[15:0];
	assign item_in.sim_time_ms       = s_tdata[47:16];
	assign item_in.autopilot_engaged = s_tdata[48];
	assign item_in.airspeed_kt       = s_tdata[58:49];
	assign item_in.lever_angle_left  = s_tdata[68:59];
	assign item_in.lever_angle_right = s_tdata[78:69];
	assign item_in.gear_left_anim    = s_tdata[93:79];
	assign item_in.gear_right_anim   = s_tdata[108:94];

	assign fire     = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || fire;
	assign s_accept = s_tvalid && s_tready;

	gsdl_eval u_eval (
		.item  (item_s1),
		.st    (st_q),
		.cfg   (cfg),
		.st_nx (st_nx),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			st_q     <= '0;
		end else begin
			valid_s1 <= s_accept || (valid_s1 && !fire);
			valid_s2 <= fire || (valid_s2 && !m_tready);
			if (fire)
				st_q <= st_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept)
			item_s1 <= item_in;
		if (fire)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2.takeoff_active, res_s2.landing_active, res_s2.armed_out,
		res_s2.handle_out, res_s2.spoiler_position};

endmodule

### rtl/core/gsdl_cfg.sv
// APB register file of the spoiler controller.
// Depends on gsdl_pkg.
module gsdl_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [gsdl_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output gsdl_pkg::cfg_t               cfg
);

	gsdl_pkg::cfg_t cfg_q;
	logic [2:0]     idx;
	logic           wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ap_limit       <= 15'd8192;
			cfg_q.partial_pos    <= 15'd8192;
			cfg_q.speed_thr      <= 10'd72;
			cfg_q.min_air_ms     <= 16'd5000;
			cfg_q.idle_angle     <= 10'sd0;
			cfg_q.climb_angle    <= 10'sd250;
			cfg_q.mct_angle      <= 10'sd350;
			cfg_q.touch_go_angle <= 10'sd200;
		end else if (wr_en) begin
			unique case (idx)
				gsdl_pkg::REG_AP_LIMIT:  cfg_q.ap_limit       <= pwdata[14:0];
				gsdl_pkg::REG_PARTIAL:   cfg_q.partial_pos    <= pwdata[14:0];
				gsdl_pkg::REG_SPEED_THR: cfg_q.speed_thr      <= pwdata[9:0];
				gsdl_pkg::REG_MIN_AIR:   cfg_q.min_air_ms     <= pwdata[15:0];
				gsdl_pkg::REG_IDLE:      cfg_q.idle_angle     <= pwdata[9:0];
				gsdl_pkg::REG_CLIMB:     cfg_q.climb_angle    <= pwdata[9:0];
				gsdl_pkg::REG_MCT:       cfg_q.mct_angle      <= pwdata[9:0];
				gsdl_pkg::REG_TOUCH_GO:  cfg_q.touch_go_angle <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			gsdl_pkg::REG_AP_LIMIT:  prdata = {17'd0, cfg_q.ap_limit};
			gsdl_pkg::REG_PARTIAL:   prdata = {17'd0, cfg_q.partial_pos};
			gsdl_pkg::REG_SPEED_THR: prdata = {22'd0, cfg_q.speed_thr};
			gsdl_pkg::REG_MIN_AIR:   prdata = {16'd0, cfg_q.min_air_ms};
			gsdl_pkg::REG_IDLE:      prdata = {22'd0, cfg_q.idle_angle};
			gsdl_pkg::REG_CLIMB:     prdata = {22'd0, cfg_q.climb_angle};
			gsdl_pkg::REG_MCT:       prdata = {22'd0, cfg_q.mct_angle};
			gsdl_pkg::REG_TOUCH_GO:  prdata = {22'd0, cfg_q.touch_go_angle};
			default:                 prdata = 32'd0;
		endcase
	end

endmodule

### rtl/core/gsdl_eval.sv
// Next-state and result logic for one event or sensor tick.
// Depends on gsdl_pkg; purely combinational.
module gsdl_eval (
	input  gsdl_pkg::item_t   item,
	input  gsdl_pkg::state_t  st,
	input  gsdl_pkg::cfg_t    cfg,
	output gsdl_pkg::state_t  st_nx,
	output gsdl_pkg::result_t res
);

	logic               do_eval;
	logic               arm_new;
	logic [14:0]        hnd_new;
	logic               ap_new;
	logic [31:0]        t;
	logic [9:0]         spd;
	logic signed [9:0]  a1;
	logic signed [9:0]  a2;
	logic [1:0]         gears;
	logic [1:0]         n;
	logic [14:0]        aplim;
	logic [14:0]        part;
	logic [14:0]        val_clamp;
	logic signed [17:0] ax_sum;
	logic [17:0]        ax_inc;
	logic [16:0]        ax_half;
	logic [14:0]        ax_pos;
	logic [31:0]        elapsed;
	logic               at_idle;
	logic               rev_idle;
	logic               below_clb;
	logic               rev_mct;
	gsdl_pkg::state_t   nx;

	assign aplim = (cfg.ap_limit > gsdl_pkg::FULL_POS) ? gsdl_pkg::FULL_POS : cfg.ap_limit;
	assign part  = (cfg.partial_pos > gsdl_pkg::FULL_POS) ? gsdl_pkg::FULL_POS : cfg.partial_pos;

	always_comb begin
		if (item.value < 16'sd0)
			val_clamp = 15'd0;
		else if (item.value > 16'sd16384)
			val_clamp = gsdl_pkg::FULL_POS;
		else
			val_clamp = item.value[14:0];
	end

	// axis: 8192 + value/2, half rounds up
	assign ax_sum  = 18'(item.value) + 18'sd16384;
	assign ax_inc  = 18'(ax_sum + 18'sd1);
	assign ax_half = ax_inc[17:1];
	always_comb begin
		if (ax_sum <= 18'sd0)
			ax_pos = 15'd0;
		else if (ax_half > 17'd16384)
			ax_pos = gsdl_pkg::FULL_POS;
		else
			ax_pos = ax_half[14:0];
	end

	always_comb begin
		do_eval = 1'b1;
		arm_new = st.armed;
		hnd_new = st.handle;
		ap_new  = st.ap_latched;
		t       = st.last_time;
		spd     = st.last_speed;
		a1      = st.angle_left;
		a2      = st.angle_right;
		gears   = st.gear;
		unique case (item.cmd)
			gsdl_pkg::CMD_TICK: begin
				t     = item.sim_time_ms;
				ap_new = item.autopilot_engaged;
				spd   = item.airspeed_kt;
				a1    = item.lever_angle_left;
				a2    = item.lever_angle_right;
				gears = {item.gear_right_anim > gsdl_pkg::HALF_POS,
					item.gear_left_anim > gsdl_pkg::HALF_POS};
			end
			gsdl_pkg::CMD_ON:         hnd_new = gsdl_pkg::FULL_POS;
			gsdl_pkg::CMD_OFF:        hnd_new = 15'd0;
			gsdl_pkg::CMD_TOGGLE:     hnd_new = (st.handle != 15'd0) ? 15'd0 : gsdl_pkg::FULL_POS;
			gsdl_pkg::CMD_SET:        hnd_new = val_clamp;
			gsdl_pkg::CMD_AXIS:       hnd_new = ax_pos;
			gsdl_pkg::CMD_ARM_ON:     arm_new = 1'b1;
			gsdl_pkg::CMD_ARM_OFF:    arm_new = 1'b0;
			gsdl_pkg::CMD_ARM_TOGGLE: arm_new = !st.armed;
			gsdl_pkg::CMD_ARM_SET:    arm_new = (item.value != 16'sd0);
			gsdl_pkg::CMD_INIT: begin
				if (st.initialized)
					do_eval = 1'b0;
				else
					hnd_new = val_clamp;
			end
			default: do_eval = 1'b0;
		endcase
	end

	assign n         = {1'b0, gears[0]} + {1'b0, gears[1]};
	assign at_idle   = (a1 <= cfg.idle_angle) && (a2 <= cfg.idle_angle);
	assign rev_idle  = ((a1 < cfg.idle_angle) && (a2 == cfg.idle_angle))
		|| ((a2 < cfg.idle_angle) && (a1 == cfg.idle_angle));
	assign below_clb = (a1 < cfg.climb_angle) && (a2 < cfg.climb_angle);
	assign rev_mct   = ((a1 < cfg.idle_angle) && (a2 < cfg.mct_angle))
		|| ((a2 < cfg.idle_angle) && (a1 < cfg.mct_angle));
	assign elapsed   = (st.stamp_valid && (t >= st.stamp)) ? (t - st.stamp) : 32'd0;

	always_comb begin
		nx = st;
		if (do_eval) begin
			if ((st.armed != arm_new) || (st.handle != hnd_new)) begin
				nx.armed   = arm_new && (hnd_new == 15'd0);
				nx.handle  = hnd_new;
				nx.surface = (ap_new && (aplim < hnd_new)) ? aplim : hnd_new;
			end
			if (ap_new && !st.ap_latched)
				nx.surface = (aplim < hnd_new) ? aplim : hnd_new;

			nx.last_time   = t;
			nx.ap_latched  = ap_new;
			nx.last_speed  = spd;
			nx.angle_left  = a1;
			nx.angle_right = a2;
			nx.gear        = gears;

			if (st.landing) begin
				if (spd < cfg.speed_thr) begin
					nx.landing     = 1'b0;
					nx.stamp_valid = 1'b0;
					nx.stamp       = 32'd0;
				end
			end else if (!st.stamp_valid && (n == 2'd0)) begin
				nx.stamp       = t;
				nx.stamp_valid = 1'b1;
			end else if (elapsed >= {16'd0, cfg.min_air_ms}) begin
				nx.landing = 1'b1;
			end

			if ((n == 2'd2) && (spd > cfg.speed_thr))
				nx.takeoff = 1'b1;
			else if ((spd < cfg.speed_thr) || (n == 2'd0))
				nx.takeoff = 1'b0;

			if (nx.takeoff && ((nx.armed && at_idle) || rev_idle))
				nx.surface = gsdl_pkg::FULL_POS;

			if (nx.landing) begin
				if (nx.armed || (nx.handle != 15'd0)) begin
					if (n == 2'd2) begin
						if (at_idle || rev_mct)
							nx.surface = gsdl_pkg::FULL_POS;
						else if (nx.armed && below_clb)
							nx.surface = part;
					end else if ((n != 2'd0) && at_idle) begin
						nx.surface = (nx.handle > part) ? nx.handle : part;
					end
				end
				if (!nx.armed && (nx.handle == 15'd0) && rev_mct) begin
					if (n == 2'd2)
						nx.surface = gsdl_pkg::FULL_POS;
					else if (n != 2'd0)
						nx.surface = part;
				end
				if ((n != 2'd0) && ((a1 > cfg.touch_go_angle) || (a2 > cfg.touch_go_angle)))
					nx.surface = nx.handle;
			end
		end
		if (item.cmd == gsdl_pkg::CMD_INIT)
			nx.initialized = 1'b1;
	end

	assign st_nx                = nx;
	assign res.spoiler_position = nx.surface;
	assign res.handle_out       = nx.handle;
	assign res.armed_out        = nx.armed;
	assign res.landing_active   = nx.landing;
	assign res.takeoff_active   = nx.takeoff;

endmodule

### rtl/core/gsdl_checker.sv
// Port-level checks for the ground spoiler controller, bound to the top level.
// Depends on gsdl_pkg and ground_spoiler_deploy_logic_assert.svh.
`include "ground_spoiler_deploy_logic_assert.svh"

module gsdl_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [gsdl_pkg::TDATA_OUT_W-1:0] m_tdata
);

	logic m_stall;
	logic res_legal;

	assign m_stall   = m_tvalid && !m_tready;
	// armed only with the handle stowed, position never above full
	assign res_legal = (!m_tdata[30] || (m_tdata[29:15] == 15'd0))
		&& (m_tdata[14:0] <= gsdl_pkg::FULL_POS);

	`GSDL_ASSERT_NXT(a_m_hold, clk, arst_n, m_stall, m_tvalid && $stable(m_tdata), "result moved")

	`GSDL_ASSERT_IMP(a_in_ready, clk, arst_n, m_tready, s_tready, "input stalled while draining")

	`GSDL_ASSERT_IMP(a_res_legal, clk, arst_n, m_tvalid, res_legal, "illegal result")

endmodule

bind ground_spoiler_deploy_logic gsdl_checker u_gsdl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### tb/tb_ground_spoiler_deploy_logic.sv
// Self-checking testbench for ground_spoiler_deploy_logic: stream driver, result monitor,
// APB register programming and a cycle-free predictor of the spoiler controller.
// Depends on gsdl_pkg and the ground_spoiler_deploy_logic RTL only.
module tb_ground_spoiler_deploy_logic;
	timeunit 1ns;
	timeprecision 1ps;

	import gsdl_pkg::*;

	localparam logic [3:0] CMD_SPARE_FIRST = 4'd11;
	localparam logic [3:0] CMD_SPARE_LAST  = 4'd15;

	localparam int LEVER_IDLE     = 0;
	localparam int LEVER_REVERSE  = 1;
	localparam int LEVER_REV_IDLE = 2;
	localparam int LEVER_TOUCH_GO = 3;
	localparam int LEVER_PARTIAL  = 4;
	localparam int LEVER_CLIMB    = 5;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata = '0;
	logic [TUSER_IN_W-1:0]  s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [PADDR_W-1:0]     paddr = '0;
	logic [31:0]            pwdata = '0;
	logic [31:0]            prdata;
	logic                   pready;

	ground_spoiler_deploy_logic i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	item_t       pending_items[$];
	result_t     awaited_results[$];
	item_t       in_flight;
	result_t     got_res, want_res;
	logic        throttle_on = 1'b1;
	logic        rx_hold = 1'b0;
	int          items_queued = 0;
	int          items_taken = 0;
	int          fault_count = 0;
	int          results_seen = 0;
	int          landing_results = 0;
	int          takeoff_results = 0;
	int          full_results = 0;
	logic [31:0] flight_ms;

	// predictor copy of the registers and the controller state
	cfg_t        cfg_shadow;
	logic        armed_q, init_q, landing_q, takeoff_q, ap_q, stamp_ok;
	logic [14:0] handle_q, surface_q;
	logic [31:0] stamp_q, time_q;
	logic [9:0]  speed_q;
	logic signed [9:0] angl_q, angr_q;
	logic [1:0]  gear_q;

	function automatic int clip(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic logic [14:0] clamp_pos(int v);
		return v < 0 ? 15'd0 : (v > 16384 ? FULL_POS : v[14:0]);
	endfunction

	function automatic void settle(logic [31:0] t, logic arm_new, logic [14:0] hnd_new,
			logic ap_new, logic [9:0] spd, int a1, int a2, logic [1:0] gears);
		logic [14:0] aplim, part;
		logic [31:0] el;
		int idl, clb, mct, tg, n;
		logic at_idle, rev_idle, below_clb, rev_mct;
		aplim = clamp_pos(int'(cfg_shadow.ap_limit));
		part = clamp_pos(int'(cfg_shadow.partial_pos));
		idl = int'($signed(cfg_shadow.idle_angle));
		clb = int'($signed(cfg_shadow.climb_angle));
		mct = int'($signed(cfg_shadow.mct_angle));
		tg = int'($signed(cfg_shadow.touch_go_angle));
		if (armed_q != arm_new || handle_q != hnd_new) begin
			armed_q = arm_new && hnd_new == 15'd0;
			handle_q = hnd_new;
			surface_q = (ap_new && aplim < hnd_new) ? aplim : hnd_new;
		end
		if (ap_new && !ap_q)
			surface_q = (aplim < hnd_new) ? aplim : hnd_new;
		time_q = t;
		ap_q = ap_new;
		speed_q = spd;
		angl_q = a1[9:0];
		angr_q = a2[9:0];
		gear_q = gears;

		n = int'(gears[0]) + int'(gears[1]);
		at_idle = a1 <= idl && a2 <= idl;
		rev_idle = (a1 < idl && a2 == idl) || (a2 < idl && a1 == idl);
		below_clb = a1 < clb && a2 < clb;
		rev_mct = (a1 < idl && a2 < mct) || (a2 < idl && a1 < mct);

		if (landing_q) begin
			if (spd < cfg_shadow.speed_thr) begin
				landing_q = 1'b0;
				stamp_ok = 1'b0;
				stamp_q = '0;
			end
		end else if (!stamp_ok && n == 0) begin
			stamp_q = t;
			stamp_ok = 1'b1;
		end else begin
			el = (stamp_ok && t >= stamp_q) ? t - stamp_q : 32'd0;
			if (el >= 32'(cfg_shadow.min_air_ms))
				landing_q = 1'b1;
		end

		if (n == 2 && spd > cfg_shadow.speed_thr)
			takeoff_q = 1'b1;
		else if (spd < cfg_shadow.speed_thr || n == 0)
			takeoff_q = 1'b0;

		if (takeoff_q && ((armed_q && at_idle) || rev_idle))
			surface_q = FULL_POS;

		if (landing_q) begin
			if (armed_q || handle_q > 0) begin
				if (n == 2) begin
					if (at_idle || rev_mct)
						surface_q = FULL_POS;
					else if (armed_q && below_clb)
						surface_q = part;
				end else if (n >= 1 && at_idle) begin
					surface_q = handle_q > part ? handle_q : part;
				end
			end
			if (!armed_q && handle_q == 15'd0 && rev_mct) begin
				if (n == 2)
					surface_q = FULL_POS;
				else if (n >= 1)
					surface_q = part;
			end
			if (n > 0 && (a1 > tg || a2 > tg))
				surface_q = handle_q;
		end
	endfunction

	// handle and arm events re-run the evaluation on the stored sensor values
	function automatic void replay(logic arm_new, logic [14:0] hnd_new);
		settle(time_q, arm_new, hnd_new, ap_q, speed_q, int'(angl_q), int'(angr_q), gear_q);
	endfunction

	function automatic result_t predict_spoiler(item_t it);
		result_t r;
		int v, t;
		logic [1:0] g;
		v = int'(it.value);
		case (it.cmd)
			CMD_TICK: begin
				g = {it.gear_right_anim > HALF_POS, it.gear_left_anim > HALF_POS};
				settle(it.sim_time_ms, armed_q, handle_q, it.autopilot_engaged, it.airspeed_kt,
					int'(it.lever_angle_left), int'(it.lever_angle_right), g);
			end
			CMD_ON:         replay(armed_q, FULL_POS);
			CMD_OFF:        replay(armed_q, 15'd0);
			CMD_TOGGLE:     replay(armed_q, handle_q > 0 ? 15'd0 : FULL_POS);
			CMD_SET:        replay(armed_q, clamp_pos(v));
			CMD_AXIS: begin
				t = v + 16384;
				replay(armed_q, t <= 0 ? 15'd0 : clamp_pos((t + 1) >>> 1));
			end
			CMD_ARM_ON:     replay(1'b1, handle_q);
			CMD_ARM_OFF:    replay(1'b0, handle_q);
			CMD_ARM_TOGGLE: replay(!armed_q, handle_q);
			CMD_ARM_SET:    replay(v != 0, handle_q);
			CMD_INIT: begin
				if (!init_q) begin
					replay(armed_q, clamp_pos(v));
					init_q = 1'b1;
				end
			end
			default: ;
		endcase
		r = '0;
		r.spoiler_position = clamp_pos(int'(surface_q));
		r.handle_out = handle_q;
		r.armed_out = armed_q;
		r.landing_active = landing_q;
		r.takeoff_active = takeoff_q;
		return r;
	endfunction

	function automatic logic [TDATA_IN_W-1:0] pack_item(item_t it);
		return {3'b000, it.gear_right_anim, it.gear_left_anim, it.lever_angle_right,
			it.lever_angle_left, it.airspeed_kt, it.autopilot_engaged, it.sim_time_ms, it.value};
	endfunction

	task automatic report_fault(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	task automatic compare_field(string name, logic [14:0] want, logic [14:0] got);
		if (got !== want)
			report_fault($sformatf("%s expected %0d got %0d", name, want, got));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				awaited_results.push_back(predict_spoiler(in_flight));
				items_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() != 0 && !(throttle_on && $urandom_range(99) < 22)) begin
					in_flight = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= pack_item(in_flight);
					s_tuser <= in_flight.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_res.spoiler_position = m_tdata[14:0];
				got_res.handle_out = m_tdata[29:15];
				got_res.armed_out = m_tdata[30];
				got_res.landing_active = m_tdata[31];
				got_res.takeoff_active = m_tdata[32];
				results_seen++;
				landing_results += int'(got_res.landing_active);
				takeoff_results += int'(got_res.takeoff_active);
				full_results += int'(got_res.spoiler_position == FULL_POS);
				if (awaited_results.size() == 0) begin
					report_fault($sformatf("result %h with no transaction outstanding", m_tdata));
				end else begin
					want_res = awaited_results.pop_front();
					compare_field("spoiler_position", want_res.spoiler_position,
						got_res.spoiler_position);
					compare_field("handle_out", want_res.handle_out, got_res.handle_out);
					compare_field("armed_out", 15'(want_res.armed_out),
						15'(got_res.armed_out));
					compare_field("landing_active", 15'(want_res.landing_active),
						15'(got_res.landing_active));
					compare_field("takeoff_active", 15'(want_res.takeoff_active),
						15'(got_res.takeoff_active));
				end
			end
			if (rx_hold)
				m_tready <= 1'b0;
			else if (throttle_on)
				m_tready <= ($urandom_range(99) >= 22);
			else
				m_tready <= 1'b1;
		end
	end

	function automatic void queue_item(item_t it);
		pending_items.push_back(it);
		items_queued++;
	endfunction

	function automatic logic [14:0] gear_val(logic down);
		return down ? 15'($urandom_range(8193, 16384)) : 15'($urandom_range(0, 8192));
	endfunction

	function automatic item_t make_tick(logic [31:0] t, logic ap, int spd, int al, int ar,
			logic [14:0] gl, logic [14:0] gr);
		item_t it;
		it.cmd = CMD_TICK;
		it.value = 16'($urandom);
		it.sim_time_ms = t;
		it.autopilot_engaged = ap;
		it.airspeed_kt = 10'(clip(spd, 0, 1023));
		it.lever_angle_left = 10'(clip(al, -512, 511));
		it.lever_angle_right = 10'(clip(ar, -512, 511));
		it.gear_left_anim = gl;
		it.gear_right_anim = gr;
		return it;
	endfunction

	// sensor fields of an event are ignored, so they carry random bits
	function automatic item_t event_item(logic [3:0] c, logic [15:0] v);
		item_t it;
		it = make_tick($urandom, 1'($urandom_range(1)), int'($urandom_range(1023)),
			int'($urandom_range(1023)) - 512, int'($urandom_range(1023)) - 512,
			15'($urandom_range(16384)), 15'($urandom_range(16384)));
		it.cmd = c;
		it.value = v;
		return it;
	endfunction

	function automatic item_t noise_item();
		item_t it;
		it = event_item(4'($urandom_range(15)), 16'($urandom));
		return it;
	endfunction

	function automatic int jitter(int c, int span);
		int r;
		r = int'($urandom_range(2 * span));
		return c - span + r;
	endfunction

	function automatic void pick_levers(int mode, output int al, output int ar);
		int idl, clb, mct, tg, tmp;
		idl = int'($signed(cfg_shadow.idle_angle));
		clb = int'($signed(cfg_shadow.climb_angle));
		mct = int'($signed(cfg_shadow.mct_angle));
		tg = int'($signed(cfg_shadow.touch_go_angle));
		case (mode)
			LEVER_IDLE: begin
				al = idl - int'($urandom_range(20));
				ar = idl - int'($urandom_range(20));
			end
			LEVER_REVERSE: begin
				al = idl - int'($urandom_range(1, 120));
				ar = jitter(mct, 40);
			end
			LEVER_REV_IDLE: begin
				al = idl - int'($urandom_range(1, 60));
				ar = idl;
			end
			LEVER_TOUCH_GO: begin
				al = tg + int'($urandom_range(1, 80));
				ar = jitter(tg, 40);
			end
			LEVER_PARTIAL: begin
				al = clb - int'($urandom_range(1, 40));
				ar = clb - int'($urandom_range(1, 40));
			end
			default: begin
				al = jitter(clb, 40);
				ar = jitter(mct, 40);
			end
		endcase
		if ($urandom_range(1)) begin
			tmp = al;
			al = ar;
			ar = tmp;
		end
	endfunction

	function automatic void flight_tick(int spd, int mode, int gears, logic ap);
		int al, ar;
		logic left_down;
		pick_levers(mode, al, ar);
		left_down = 1'($urandom_range(1));
		queue_item(make_tick(flight_ms, ap, spd, al, ar,
			gear_val(gears == 2 || (gears == 1 && left_down)),
			gear_val(gears == 2 || (gears == 1 && !left_down))));
	endfunction

	function automatic void approach_event();
		case ($urandom_range(7))
			0: queue_item(event_item(CMD_ON, 16'($urandom)));
			1: queue_item(event_item(CMD_TOGGLE, 16'($urandom)));
			2: queue_item(event_item(CMD_SET, 16'($urandom_range(16384))));
			3: queue_item(event_item(CMD_AXIS, 16'($urandom)));
			4: queue_item(event_item(CMD_ARM_OFF, 16'($urandom)));
			5: queue_item(event_item(CMD_ARM_TOGGLE, 16'($urandom)));
			default: begin
				queue_item(event_item(CMD_OFF, 16'($urandom)));
				queue_item(event_item(CMD_ARM_ON, 16'($urandom)));
			end
		endcase
	endfunction

	// take-off roll, then either a rejected take-off or a flight and a landing
	function automatic void add_flight();
		int thr, spd, k, reps, mode;
		logic [31:0] step;
		thr = int'(cfg_shadow.speed_thr);
		if ($urandom_range(4) == 0)
			queue_item(event_item(CMD_INIT, 16'($urandom)));
		case ($urandom_range(3))
			0: begin
				queue_item(event_item(CMD_OFF, 16'($urandom)));
				queue_item(event_item(CMD_ARM_ON, 16'($urandom)));
			end
			1: queue_item(event_item(CMD_ARM_SET, 16'($urandom)));
			2: queue_item(event_item(CMD_ARM_TOGGLE, 16'($urandom)));
			default: queue_item(event_item(CMD_AXIS, 16'($urandom)));
		endcase
		spd = thr - int'($urandom_range(20));
		reps = int'($urandom_range(2, 5));
		for (k = 0; k < reps; k++) begin
			spd += int'($urandom_range(5, 30));
			flight_ms += $urandom_range(20, 400);
			flight_tick(spd, LEVER_CLIMB, 2, $urandom_range(7) == 0);
		end
		if ($urandom_range(3) == 0) begin
			mode = $urandom_range(1) ? LEVER_IDLE : LEVER_REV_IDLE;
			reps = int'($urandom_range(2, 5));
			for (k = 0; k < reps; k++) begin
				spd -= int'($urandom_range(10, 40));
				flight_ms += $urandom_range(20, 400);
				flight_tick(spd, mode, 2, 1'b0);
			end
			return;
		end
		step = 32'(cfg_shadow.min_air_ms / 2) + $urandom_range(1, 1500);
		reps = int'($urandom_range(2, 4));
		for (k = 0; k < reps; k++) begin
			flight_ms += step;
			flight_tick(thr + int'($urandom_range(50, 200)), LEVER_CLIMB, 0,
				$urandom_range(3) == 0);
		end
		reps = int'($urandom_range(1, 3));
		for (k = 0; k < reps; k++)
			approach_event();
		mode = int'($urandom_range(LEVER_PARTIAL));
		spd = thr + int'($urandom_range(10, 60));
		flight_ms += $urandom_range(20, 400);
		flight_tick(spd, mode, 1, $urandom_range(7) == 0);
		reps = int'($urandom_range(2, 6));
		for (k = 0; k < reps; k++) begin
			if ($urandom_range(3) == 0)
				mode = int'($urandom_range(LEVER_PARTIAL));
			spd -= int'($urandom_range(5, 40));
			flight_ms += $urandom_range(20, 400);
			flight_tick(spd, mode, 2, 1'b0);
		end
		if (spd >= thr) begin
			flight_ms += $urandom_range(20, 400);
			flight_tick(thr - int'($urandom_range(1, 10)), mode, 2, 1'b0);
		end
	endfunction

	function automatic void fill_random(int target);
		int first;
		first = items_queued;
		while (items_queued - first < target) begin
			if ($urandom_range(9) < 8)
				add_flight();
			else
				repeat ($urandom_range(1, 4)) queue_item(noise_item());
		end
	endfunction

	task automatic wait_quiet();
		while (items_taken != items_queued || awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic program_reg(logic [2:0] idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_AP_LIMIT:  cfg_shadow.ap_limit = v[14:0];
			REG_PARTIAL:   cfg_shadow.partial_pos = v[14:0];
			REG_SPEED_THR: cfg_shadow.speed_thr = v[9:0];
			REG_MIN_AIR:   cfg_shadow.min_air_ms = v[15:0];
			REG_IDLE:      cfg_shadow.idle_angle = v[9:0];
			REG_CLIMB:     cfg_shadow.climb_angle = v[9:0];
			REG_MCT:       cfg_shadow.mct_angle = v[9:0];
			REG_TOUCH_GO:  cfg_shadow.touch_go_angle = v[9:0];
			default: ;
		endcase
	endtask

	task automatic program_all(cfg_t c);
		program_reg(REG_AP_LIMIT, {17'd0, c.ap_limit});
		program_reg(REG_PARTIAL, {17'd0, c.partial_pos});
		program_reg(REG_SPEED_THR, {22'd0, c.speed_thr});
		program_reg(REG_MIN_AIR, {16'd0, c.min_air_ms});
		program_reg(REG_IDLE, {22'd0, c.idle_angle});
		program_reg(REG_CLIMB, {22'd0, c.climb_angle});
		program_reg(REG_MCT, {22'd0, c.mct_angle});
		program_reg(REG_TOUCH_GO, {22'd0, c.touch_go_angle});
	endtask

	initial begin
		rx_hold <= 1'b0;
		wait (items_taken >= 120);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		#2ms;
		$display("ground_spoiler_deploy_logic regression: fail");
		$finish;
	end

	initial begin
		cfg_t next_cfg;
		int p, idl, clb;
		cfg_shadow = '0;
		cfg_shadow.ap_limit = 15'd8192;
		cfg_shadow.partial_pos = 15'd8192;
		cfg_shadow.speed_thr = 10'd72;
		cfg_shadow.min_air_ms = 16'd5000;
		cfg_shadow.climb_angle = 10'sd250;
		cfg_shadow.mct_angle = 10'sd350;
		cfg_shadow.touch_go_angle = 10'sd200;
		{armed_q, init_q, landing_q, takeoff_q, ap_q, stamp_ok} = '0;
		{handle_q, surface_q, stamp_q, time_q, speed_q, angl_q, angr_q, gear_q} = '0;
		flight_ms = $urandom;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// a zero tick, handle and arm commands at their extremes, spare command codes, then sensor corner cases
		queue_item(make_tick(32'd0, 1'b0, 0, 0, 0, 15'd0, 15'd0));
		queue_item(event_item(CMD_INIT, 16'sd20000));
		queue_item(event_item(CMD_INIT, -16'sd5));
		queue_item(event_item(CMD_SET, 16'h8000));
		queue_item(event_item(CMD_SET, 16'h7FFF));
		queue_item(event_item(CMD_AXIS, 16'h8000));
		queue_item(event_item(CMD_AXIS, 16'h7FFF));
		queue_item(event_item(CMD_AXIS, 16'sd1));
		queue_item(event_item(CMD_AXIS, -16'sd1));
		queue_item(event_item(CMD_ON, 16'($urandom)));
		queue_item(event_item(CMD_TOGGLE, 16'($urandom)));
		queue_item(event_item(CMD_TOGGLE, 16'($urandom)));
		queue_item(event_item(CMD_OFF, 16'($urandom)));
		queue_item(event_item(CMD_ARM_ON, 16'($urandom)));
		queue_item(event_item(CMD_ARM_OFF, 16'($urandom)));
		queue_item(event_item(CMD_ARM_TOGGLE, 16'($urandom)));
		queue_item(event_item(CMD_ARM_SET, 16'd0));
		queue_item(event_item(CMD_ARM_SET, 16'hFFFF));
		queue_item(event_item(CMD_SPARE_FIRST, 16'($urandom)));
		queue_item(event_item(CMD_SPARE_LAST, 16'($urandom)));
		queue_item(make_tick(32'hFFFF_FFFF, 1'b1, 1023, -512, 511, FULL_POS, HALF_POS));
		queue_item(make_tick(32'd0, 1'b0, 100, 0, 0, 15'd8193, 15'd8193));
		queue_item(make_tick(32'd40, 1'b0, 100, -10, 0, FULL_POS, FULL_POS));
		queue_item(make_tick(32'd80, 1'b0, 100, -30, 340, FULL_POS, 15'd8193));
		queue_item(make_tick(32'd120, 1'b0, 0, 0, 0, FULL_POS, FULL_POS));
		fill_random(250);
		wait_quiet();

		for (p = 0; p < 6; p++) begin
			case (p)
				0: begin
					next_cfg.ap_limit = 15'h7FFF;
					next_cfg.partial_pos = 15'h7FFF;
					next_cfg.speed_thr = 10'd1023;
					next_cfg.min_air_ms = 16'hFFFF;
					next_cfg.idle_angle = 10'sd511;
					next_cfg.climb_angle = 10'sd511;
					next_cfg.mct_angle = 10'sd511;
					next_cfg.touch_go_angle = 10'sd511;
				end
				1: begin
					next_cfg = '0;
					next_cfg.idle_angle = -10'sd512;
					next_cfg.climb_angle = -10'sd512;
					next_cfg.mct_angle = -10'sd512;
					next_cfg.touch_go_angle = -10'sd512;
				end
				default: begin
					next_cfg.ap_limit = ($urandom_range(7) == 0) ? 15'($urandom)
						: 15'($urandom_range(16384));
					next_cfg.partial_pos = ($urandom_range(7) == 0) ? 15'($urandom)
						: 15'($urandom_range(16384));
					next_cfg.speed_thr = 10'($urandom_range(20, 300));
					next_cfg.min_air_ms = 16'($urandom_range(8000));
					idl = int'($urandom_range(150)) - 100;
					clb = clip(idl + int'($urandom_range(50, 250)), -512, 511);
					next_cfg.idle_angle = 10'(idl);
					next_cfg.climb_angle = 10'(clb);
					next_cfg.mct_angle = 10'(clip(clb + int'($urandom_range(150)), -512, 511));
					next_cfg.touch_go_angle = 10'(clip(idl + int'($urandom_range(300)), -512, 511));
				end
			endcase
			program_all(next_cfg);
			throttle_on <= (p != 3);
			fill_random(p < 2 ? 150 : 200);
			wait_quiet();
		end

		repeat (8) @(posedge clk);
		if (awaited_results.size() != 0)
			report_fault($sformatf("%0d results never arrived", awaited_results.size()));
		$display("Checked %0d results over 7 register settings, with a long output stall.",
			results_seen);
		$display("Landing active in %0d, take-off roll in %0d, full deployment in %0d.",
			landing_results, takeoff_results, full_results);
		if (fault_count == 0)
			$display("ground_spoiler_deploy_logic regression: pass");
		else
			$display("ground_spoiler_deploy_logic regression: fail");
		$finish;
	end

endmodule
